/* design/slope_feedforward_current_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef SLOPE_FEEDFORWARD_CURRENT_TOP_DEFINES_SVH
`define SLOPE_FEEDFORWARD_CURRENT_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SFC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sfc check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SFC_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sfc check failed");
`endif

/* design/sfc_pkg.sv */
//------------------------------------------------------------------------------
// sfc_pkg
// Types, constants and tables shared by the slope feedforward current block.
//------------------------------------------------------------------------------
`default_nettype none
package sfc_pkg;
  localparam int unsigned Wheels      = 4;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned TableLen    = 24;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] RegTorqueGain   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRearShift    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRollingCoeff = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepLimit    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSlopeThresh  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLowSpdThresh = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLowSpdRatio  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMaxComp      = 3'd7;

  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] GainQ30   = 36'sd652032874;
  localparam logic [35:0]        CosEpsQ30 = 36'd1073742;
  localparam logic [19:0]        TanCapQ16 = 20'd655360;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORDIC, ST_POST, ST_DIV, ST_MODE,
    ST_WHEEL, ST_OUT
  } state_e;

  typedef struct packed {
    logic [14:0]        torque_gain;
    logic [14:0]        rear_shift;
    logic [14:0]        rolling_coeff;
    logic [14:0]        step_limit;
    logic signed [15:0] pitch_sin_floor;
    logic [14:0]        low_speed_threshold;
    logic [15:0]        slow_gain;
    logic [14:0]        comp_limit;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    torque_gain: 15'd0, rear_shift: 15'd0, rolling_coeff: 15'd0, step_limit: 15'd0,
    pitch_sin_floor: 16'sd32767, low_speed_threshold: 15'd0, slow_gain: 16'd4096,
    comp_limit: 15'd0
  };

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic cordic_step;
    logic post;
    logic div_step;
    logic mode;
    logic wheel_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cordic_done;
    logic div_done;
    logic wheel_done;
  } status_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] r;
    case (i)
      5'd0: r = 36'sd843314857;  5'd1: r = 36'sd497837829;
      5'd2: r = 36'sd263043837;  5'd3: r = 36'sd133525159;
      5'd4: r = 36'sd67021687;   5'd5: r = 36'sd33543516;
      5'd6: r = 36'sd16775851;   5'd7: r = 36'sd8388437;
      5'd8: r = 36'sd4194283;    5'd9: r = 36'sd2097149;
      default: r = 36'sd1 <<< (5'd30 - i);
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* design/sfc_if.sv */
//------------------------------------------------------------------------------
// sfc_if
// Valid/ready channel carrying a packed payload.
//------------------------------------------------------------------------------
`default_nettype none
interface sfc_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/sfc_ctrl.sv */
//------------------------------------------------------------------------------
// sfc_ctrl
// Sequencer: load, CORDIC, tangent divide, per-wheel math, output hold.
//------------------------------------------------------------------------------
`default_nettype none
module sfc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sfc_pkg::cmd_t         cmd_o,
  input  wire sfc_pkg::status_t sts_i
);
  sfc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sfc_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfc_pkg::ST_IDLE:   if (in_valid_i) state_d = sfc_pkg::ST_CORDIC;
      sfc_pkg::ST_CORDIC: if (sts_i.cordic_done) state_d = sfc_pkg::ST_POST;
      sfc_pkg::ST_POST:   state_d = sfc_pkg::ST_DIV;
      sfc_pkg::ST_DIV:    if (sts_i.div_done) state_d = sfc_pkg::ST_MODE;
      sfc_pkg::ST_MODE:   state_d = sfc_pkg::ST_WHEEL;
      sfc_pkg::ST_WHEEL:  if (sts_i.wheel_done) state_d = sfc_pkg::ST_OUT;
      sfc_pkg::ST_OUT:    if (out_ready_i) state_d = sfc_pkg::ST_IDLE;
      default:            state_d = sfc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      // operands are captured on the input transfer itself
      sfc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sfc_pkg::ST_CORDIC: cmd_o.cordic_step = 1'b1;
      sfc_pkg::ST_POST:   cmd_o.post = 1'b1;
      sfc_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      sfc_pkg::ST_MODE:   cmd_o.mode = 1'b1;
      sfc_pkg::ST_WHEEL:  cmd_o.wheel_step = 1'b1;
      sfc_pkg::ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* design/sfc_dp.sv */
//------------------------------------------------------------------------------
// sfc_dp
// Datapath: two CORDIC rotators, restoring divider, per-wheel pipeline.
//------------------------------------------------------------------------------
`default_nettype none
module sfc_dp #(
  parameter int unsigned CORDIC_STEPS = sfc_pkg::CordicSteps
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfc_pkg::cmd_t     cmd_i,
  output sfc_pkg::status_t       sts_o,
  input  wire sfc_pkg::cfg_t     cfg_i,
  input  wire logic [159:0]      in_data_i,
  output logic [59:0]            out_data_o
);
  localparam int unsigned W = sfc_pkg::Wheels;

  // ---------------- input latch
  logic signed [15:0] pitch_q;
  logic signed [15:0] spd_q [W];
  logic signed [15:0] cur_q [W];
  logic [14:0]        prev_q [W];

  logic cordic_done, div_done, wheel_done;

  // ---------------- CORDIC
  logic signed [35:0] zp_q, xp_q, yp_q, zy_q, xy_q, yy_q;
  logic               negp_q, negy_q;
  logic [4:0]         it_q;
  logic signed [35:0] zp0, zy0;
  logic               np0, ny0;

  always_comb begin
    zp0 = 36'(signed'(in_data_i[15:0])) <<< 17;
    zy0 = 36'(signed'(in_data_i[31:16])) <<< 17;
    np0 = 1'b0; ny0 = 1'b0;
    if (zp0 > sfc_pkg::HalfPiQ30) begin
      zp0 = zp0 - sfc_pkg::PiQ30; np0 = 1'b1;
    end else if (zp0 < -sfc_pkg::HalfPiQ30) begin
      zp0 = zp0 + sfc_pkg::PiQ30; np0 = 1'b1;
    end
    if (zy0 > sfc_pkg::HalfPiQ30) begin
      zy0 = zy0 - sfc_pkg::PiQ30; ny0 = 1'b1;
    end else if (zy0 < -sfc_pkg::HalfPiQ30) begin
      zy0 = zy0 + sfc_pkg::PiQ30; ny0 = 1'b1;
    end
  end

  logic signed [35:0] at;
  assign at = sfc_pkg::atan_q30(it_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) it_q <= '0;
    else if (cmd_i.load) it_q <= '0;
    else if (cmd_i.cordic_step) it_q <= it_q + 5'd1;
  end
  assign cordic_done = cmd_i.cordic_step && (it_q == 5'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pitch_q <= in_data_i[15:0];
      for (int i = 0; i < W; i++) begin
        spd_q[i] <= in_data_i[32 + 16*i +: 16];
        cur_q[i] <= in_data_i[96 + 16*i +: 16];
      end
      zp_q <= zp0; zy_q <= zy0; negp_q <= np0; negy_q <= ny0;
      xp_q <= sfc_pkg::GainQ30; yp_q <= '0;
      xy_q <= sfc_pkg::GainQ30; yy_q <= '0;
    end else if (cmd_i.cordic_step) begin
      if (zp_q >= 0) begin
        xp_q <= xp_q - (yp_q >>> it_q); yp_q <= yp_q + (xp_q >>> it_q); zp_q <= zp_q - at;
      end else begin
        xp_q <= xp_q + (yp_q >>> it_q); yp_q <= yp_q - (xp_q >>> it_q); zp_q <= zp_q + at;
      end
      if (zy_q >= 0) begin
        xy_q <= xy_q - (yy_q >>> it_q); yy_q <= yy_q + (xy_q >>> it_q); zy_q <= zy_q - at;
      end else begin
        xy_q <= xy_q + (yy_q >>> it_q); yy_q <= yy_q - (xy_q >>> it_q); zy_q <= zy_q + at;
      end
    end
  end

  // ---------------- post: Q1.15 conversion and tangent setup
  logic signed [35:0] sp, cp, sy, cy;
  assign sp = negp_q ? -yp_q : yp_q;
  assign cp = negp_q ? -xp_q : xp_q;
  assign sy = negy_q ? -yy_q : yy_q;
  assign cy = negy_q ? -xy_q : xy_q;

  function automatic logic signed [15:0] to_q15(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + 36'sd16384) >>> 15;
    if (r > 36'sd32767) return 16'sd32767;
    if (r < -36'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  logic signed [15:0] s_q, c_q;
  logic [35:0]        ac_q;
  logic               tan_ok_q;
  // restoring divider: quotient of (as<<16)/ac, 48-bit dividend
  logic [47:0]        dvd_q;
  logic [36:0]        rem_q;
  logic [5:0]         dcnt_q;
  logic [36:0]        rem_sh, rem_sub;

  assign rem_sh  = {rem_q[35:0], dvd_q[47]};
  assign rem_sub = rem_sh - {1'b0, ac_q};
  assign div_done = cmd_i.div_step && (dcnt_q == 6'd47);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dcnt_q <= '0;
    else if (cmd_i.post) dcnt_q <= '0;
    else if (cmd_i.div_step) dcnt_q <= dcnt_q + 6'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      s_q      <= to_q15(sp);
      c_q      <= to_q15(cp);
      ac_q     <= cy[35] ? 36'(-cy) : 36'(cy);
      dvd_q    <= {(sy[35] ? 32'(-sy) : 32'(sy)), 16'd0};
      rem_q    <= '0;
      tan_ok_q <= (cy[35] ? 36'(-cy) : 36'(cy)) > sfc_pkg::CosEpsQ30;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[46:0], ~rem_sub[36]};
      rem_q <= rem_sub[36] ? rem_sh : rem_sub;
    end
  end

  // ---------------- mode and per-wheel pipeline
  logic [19:0]        tan_q;
  logic               flat_q;
  logic signed [16:0] ks_q;
  logic signed [19:0] f_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mode) begin
      tan_q  <= (!tan_ok_q) ? 20'd0 :
                (dvd_q > 48'(sfc_pkg::TanCapQ16)) ? sfc_pkg::TanCapQ16 : dvd_q[19:0];
      flat_q <= (pitch_q <= 0) || (s_q <= cfg_i.pitch_sin_floor);
      ks_q   <= 17'((33'(signed'({1'b0, cfg_i.rear_shift})) * 33'(s_q)) >>> 15);
    end
  end

  // stage registers: 0 F and gain*mf, 1 *F, 2 target, 3 boost, 4 clamp+ramp
  logic signed [17:0] mf;
  logic signed [35:0] g_mf_q;
  logic signed [55:0] prod_q;
  logic signed [41:0] tgt_q;
  logic signed [36:0] st;
  logic signed [33:0] cr;

  // five phases per wheel, wheel index advances after the ramp phase
  logic [2:0] ph_q;
  logic [1:0] cw_q;
  logic signed [16:0] spd_abs;
  logic signed [17:0] mx12, bycur, allow, mxs;
  logic signed [41:0] tcl;
  logic signed [17:0] p, pn, stp;
  logic [14:0] mx;

  assign mf = (cw_q >= 2'd2) ? 18'sd32768 + 18'(ks_q) : 18'sd32768 - 18'(ks_q);
  assign cr = 34'(c_q) * 34'(signed'({1'b0, cfg_i.rolling_coeff}));
  assign st = 37'(s_q) * 37'(signed'({1'b0, tan_q}));
  assign wheel_done = cmd_i.wheel_step && (ph_q == 3'd4) && (cw_q == 2'd3);

  assign mx  = cfg_i.comp_limit;
  assign mxs = $signed({3'b000, mx});
  assign stp = 18'(cfg_i.step_limit);
  assign p   = 18'(prev_q[cw_q]);
  assign spd_abs = spd_q[cw_q][15] ? -17'(spd_q[cw_q]) : 17'(spd_q[cw_q]);
  // floor(mx*6/5) via reciprocal: (mx*6*52429)>>18 exact for mx < 2^15
  assign mx12  = 18'((36'(mx) * 36'd6 * 36'd52429) >> 18);
  assign bycur = mx12 - (18'(cur_q[cw_q]) - p);

  always_comb begin
    allow = (bycur < mxs) ? bycur : mxs;
    tcl   = (tgt_q > 42'(allow)) ? 42'(allow) : tgt_q;
    if (tcl < 0) tcl = '0;
    if (flat_q)                     pn = (p > stp) ? p - stp : '0;
    else if (tcl > 42'(p + stp))    pn = p + stp;
    else if (tcl < 42'(p - stp))    pn = p - stp;
    else                            pn = 18'(tcl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < W; i++) prev_q[i] <= '0;
      ph_q <= '0;
      cw_q <= '0;
    end else if (cmd_i.mode) begin
      ph_q <= '0; cw_q <= '0;
    end else if (cmd_i.wheel_step) begin
      if (ph_q == 3'd4) begin
        prev_q[cw_q] <= pn[14:0];
        ph_q <= '0;
        cw_q <= cw_q + 2'd1;
      end else ph_q <= ph_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wheel_step) begin
      unique case (ph_q)
        3'd0: begin
          f_q    <= 20'(s_q) + 20'(cr >>> 15) + 20'(st >>> 16);
          g_mf_q <= 36'(signed'({1'b0, cfg_i.torque_gain})) * 36'(mf);
        end
        3'd1: prod_q <= 56'(g_mf_q) * 56'(f_q);
        3'd2: tgt_q  <= 42'(prod_q >>> 30);
        3'd3: if (17'(spd_abs) < 17'(cfg_i.low_speed_threshold))
                tgt_q <= 42'((58'(tgt_q) * 58'(signed'({1'b0, cfg_i.slow_gain}))) >>> 12);
        default: ;
      endcase
    end
  end

  assign sts_o = '{cordic_done: cordic_done, div_done: div_done, wheel_done: wheel_done};

  always_comb begin
    for (int i = 0; i < W; i++) out_data_o[15*i +: 15] = prev_q[i];
  end
endmodule
`default_nettype wire

/* design/slope_feedforward_current_top.sv */
//------------------------------------------------------------------------------
// slope_feedforward_current_top
// Slope feedforward compensation current for a four-wheel chassis.
//------------------------------------------------------------------------------
// Input channel in_if carries pitch, yaw, four speeds and four currents;
// output channel out_if carries four compensation currents.
// One item at a time: after a transfer the block runs CORDIC_STEPS rotation
// steps (pitch and yaw in parallel), a post step, a 48-step restoring
// divide for the yaw tangent, a mode step and five steps per wheel.
// The run time is set mostly by the divider and the per-wheel multiply chain.
// The result is held on out_if until transferred; in_if is not ready again
// until then, so a stalled receiver stalls the sender.
// Reset clears the registers to their reset values and the stored currents
// to zero. Configuration writes go on cfg_we_i / cfg_idx_i / cfg_data_i;
// the user makes them while the block is idle, and the block itself does
// not enforce it. All eight values of cfg_idx_i name a register.
//------------------------------------------------------------------------------
`default_nettype none
module slope_feedforward_current_top #(
  parameter int unsigned CORDIC_STEPS = sfc_pkg::CordicSteps
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sfc_if.sink                                in_if,
  sfc_if.source                              out_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sfc_pkg::CfgDataW-1:0]  cfg_data_i
);
  sfc_pkg::cfg_t    cfg_q;
  sfc_pkg::cmd_t    cmd;
  sfc_pkg::status_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sfc_pkg::CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfc_pkg::RegTorqueGain:   cfg_q.torque_gain <= cfg_data_i[14:0];
        sfc_pkg::RegRearShift:    cfg_q.rear_shift <= cfg_data_i[14:0];
        sfc_pkg::RegRollingCoeff: cfg_q.rolling_coeff <= cfg_data_i[14:0];
        sfc_pkg::RegStepLimit:    cfg_q.step_limit <= cfg_data_i[14:0];
        sfc_pkg::RegSlopeThresh:  cfg_q.pitch_sin_floor <= cfg_data_i;
        sfc_pkg::RegLowSpdThresh: cfg_q.low_speed_threshold <= cfg_data_i[14:0];
        sfc_pkg::RegLowSpdRatio:  cfg_q.slow_gain <= cfg_data_i;
        sfc_pkg::RegMaxComp:      cfg_q.comp_limit <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  sfc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .cmd_o(cmd), .sts_i(sts)
  );

  sfc_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_i(cfg_q),
    .in_data_i(in_if.data), .out_data_o(out_if.data)
  );
endmodule
`default_nettype wire

/* design/sfc_checker.sv */
//------------------------------------------------------------------------------
// sfc_checker
// Port-level checks of the slope feedforward current block.
//------------------------------------------------------------------------------
`default_nettype none
`include "slope_feedforward_current_top_defines.svh"
module sfc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  // one item at a time: never ready while a result is offered
  `SFC_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid, !in_ready)
  // a transfer in leaves the input side busy
  `SFC_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid && in_ready, !in_ready && !out_valid)
  // an offered result stays until taken
  `SFC_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  // after delivery the block is ready again
  `SFC_ASSERT_NXT(a_back, clk_i, rst_ni, out_valid && out_ready, in_ready)
endmodule

bind slope_feedforward_current_top sfc_checker u_sfc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready)
);
`default_nettype wire

/* bench/slope_feedforward_current_top_tb.sv */
//------------------------------------------------------------------------------
// slope_feedforward_current_top_tb
// Self-checking bench for the slope feedforward current block: a directed
// table followed by random control periods under several register settings,
// with each result compared against a typed value or an in-bench predictor.
//------------------------------------------------------------------------------
`default_nettype none
module slope_feedforward_current_top_tb;

  // pitch sits in the low bits, current of wheel 3 in the high bits
  typedef struct packed {
    logic signed [15:0] cur3, cur2, cur1, cur0;
    logic signed [15:0] speed3, speed2, speed1, speed0;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
  } period_t;

  typedef struct packed {
    logic [14:0] comp3, comp2, comp1, comp0;
  } comp_t;

  typedef struct {
    period_t     din;
    bit          typed;
    logic [14:0] c0, c1, c2, c3;
  } row_t;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainWait = 200;
  localparam int unsigned IdxW      = sfc_pkg::CfgIdxW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [sfc_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [sfc_pkg::CfgDataW-1:0] cfg_data = '0;

  sfc_if #(.W($bits(period_t))) in_ch ();
  sfc_if #(.W($bits(comp_t)))   out_ch ();

  slope_feedforward_current_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and register copy
  longint gain_m, shift_m, roll_m, step_m, thr_m, lst_m, ratio_m, maxc_m;
  longint stored_comp [4];
  comp_t  comp_queue [$];
  int     errors = 0;
  int     periods_sent = 0;
  int     results_seen = 0;
  bit     quiet = 1'b0;
  int     idle_cycles = 0;

  longint atan_tab [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  function automatic void rotate(input longint ang, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit     neg;
    z = ang * 131072;
    x = 652032874;
    y = 0;
    neg = 1'b0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      neg = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      neg = 1'b1;
    end
    for (int i = 0; i < sfc_pkg::CordicSteps && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += atan_tab[i];
      end
      x = nx;
    end
    sn = neg ? -y : y;
    cs = neg ? -x : x;
  endfunction

  function automatic longint q30_to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // Advances the stored currents by one control period and returns them.
  function automatic comp_t next_comp(input period_t d);
    longint sp, cp, sy, cy, s, c, tanq, as_y, ac_y;
    longint ks, mf, f, target, spd, cur, allow, by_cur, p;
    longint spds [4];
    longint curs [4];
    comp_t  r;
    spds = '{d.speed0, d.speed1, d.speed2, d.speed3};
    curs = '{d.cur0, d.cur1, d.cur2, d.cur3};
    rotate(longint'(d.pitch), sp, cp);
    rotate(longint'(d.yaw), sy, cy);
    s = q30_to_q15(sp);
    c = q30_to_q15(cp);
    tanq = 0;
    as_y = (sy < 0) ? -sy : sy;
    ac_y = (cy < 0) ? -cy : cy;
    if (ac_y > 1073742) begin
      tanq = (as_y * 65536) / ac_y;
      if (tanq > 655360) tanq = 655360;
    end
    for (int i = 0; i < 4; i++) begin
      p = stored_comp[i];
      if (d.pitch <= 0 || s <= thr_m) begin
        p = (p > step_m) ? p - step_m : 0;
      end else begin
        ks = (shift_m * s) >>> 15;
        mf = (i >= 2) ? 32768 + ks : 32768 - ks;
        f = s + ((c * roll_m) >>> 15) + ((s * tanq) >>> 16);
        target = (gain_m * mf * f) >>> 30;
        spd = (spds[i] < 0) ? -spds[i] : spds[i];
        cur = curs[i];
        if (spd < lst_m) target = (target * ratio_m) >>> 12;
        allow = maxc_m;
        by_cur = (maxc_m * 6) / 5 - (cur - p);
        if (by_cur < allow) allow = by_cur;
        if (target > allow) target = allow;
        if (target < 0) target = 0;
        if (target > p + step_m) p = p + step_m;
        else if (target < p - step_m) p = p - step_m;
        else p = target;
      end
      stored_comp[i] = p;
    end
    r.comp0 = stored_comp[0][14:0];
    r.comp1 = stored_comp[1][14:0];
    r.comp2 = stored_comp[2][14:0];
    r.comp3 = stored_comp[3][14:0];
    return r;
  endfunction

  // Writes all eight registers back to back; block must be idle.
  task automatic write_regs(input logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= IdxW'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
      case (IdxW'(i))
        sfc_pkg::RegTorqueGain:   gain_m  = vals[i][14:0];
        sfc_pkg::RegRearShift:    shift_m = vals[i][14:0];
        sfc_pkg::RegRollingCoeff: roll_m  = vals[i][14:0];
        sfc_pkg::RegStepLimit:    step_m  = vals[i][14:0];
        sfc_pkg::RegSlopeThresh:  thr_m   = longint'($signed(vals[i]));
        sfc_pkg::RegLowSpdThresh: lst_m   = vals[i][14:0];
        sfc_pkg::RegLowSpdRatio:  ratio_m = vals[i];
        sfc_pkg::RegMaxComp:      maxc_m  = vals[i][14:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (comp_queue.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Holds valid until the transfer; caller decides when to drop it.
  task automatic send_period(input period_t d, input bit typed, input comp_t typed_val);
    comp_t pred;
    if (!quiet && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    pred = next_comp(d);
    comp_queue.push_back(typed ? typed_val : pred);
    periods_sent++;
  endtask

  function automatic logic signed [15:0] pick_speed();
    if ($urandom_range(2) == 0) return 16'($signed($urandom_range(0, 600)) - 300);
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_current();
    if ($urandom_range(2) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 3000)) - 1000);
  endfunction

  function automatic period_t random_period();
    period_t d;
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) d.pitch = 16'($urandom_range(1, 25736));
    else if (sel < 90) d.pitch = -16'($urandom_range(0, 25736));
    else d.pitch = 16'($urandom);
    sel = $urandom_range(99);
    if (sel < 10) d.yaw = 16'($signed($urandom_range(12860, 12876)) * (($urandom_range(1)) ? 1 : -1));
    else if (sel < 85) d.yaw = 16'($signed($urandom_range(0, 51472)) - 25736);
    else d.yaw = 16'($urandom);
    d.speed0 = pick_speed(); d.speed1 = pick_speed();
    d.speed2 = pick_speed(); d.speed3 = pick_speed();
    d.cur0 = pick_current(); d.cur1 = pick_current();
    d.cur2 = pick_current(); d.cur3 = pick_current();
    return d;
  endfunction

  // sink side: random backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet || ($urandom_range(99) >= 10);
  end

  // result checker
  always @(posedge clk_i) begin
    comp_t got, want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (comp_queue.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, got);
        errors++;
      end else begin
        want = comp_queue.pop_front();
        if (got.comp0 !== want.comp0) begin
          $display("%0t: comp_w0 expected %0d actual %0d", $time, want.comp0, got.comp0);
          errors++;
        end
        if (got.comp1 !== want.comp1) begin
          $display("%0t: comp_w1 expected %0d actual %0d", $time, want.comp1, got.comp1);
          errors++;
        end
        if (got.comp2 !== want.comp2) begin
          $display("%0t: comp_w2 expected %0d actual %0d", $time, want.comp2, got.comp2);
          errors++;
        end
        if (got.comp3 !== want.comp3) begin
          $display("%0t: comp_w3 expected %0d actual %0d", $time, want.comp3, got.comp3);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("slope_feedforward_current_top verification failed");
      $finish;
    end
  end

  function automatic period_t mk(input int p, input int y, input int s, input int c);
    period_t d;
    d.pitch = 16'(p); d.yaw = 16'(y);
    d.speed0 = 16'(s); d.speed1 = 16'(-s); d.speed2 = 16'(s); d.speed3 = 16'(-s);
    d.cur0 = 16'(c); d.cur1 = 16'(-c); d.cur2 = 16'(c); d.cur3 = 16'(~c);
    return d;
  endfunction

  initial begin
    row_t        rows [$];
    row_t        rw;
    comp_t       tv;
    period_t     d;
    logic [15:0] regs [8];
    int          n_phase;

    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    gain_m = 0; shift_m = 0; roll_m = 0; step_m = 0;
    thr_m = 32767; lst_m = 0; ratio_m = 4096; maxc_m = 0;
    stored_comp = '{0, 0, 0, 0};

    // reset defaults: zero gain and limits keep every output at zero
    rows.push_back('{mk(25736, 0, 0, 0), 1, 0, 0, 0, 0});
    rows.push_back('{mk(-32768, -32768, -32768, -32768), 1, 0, 0, 0, 0});
    rows.push_back('{mk(32767, 32767, 32767, 32767), 1, 0, 0, 0, 0});
    rows.push_back('{mk(0, 25736, 100, -100), 1, 0, 0, 0, 0});
    // same shapes, predicted under an active setting
    rows.push_back('{mk(4000, 0, 0, 0), 0, 0, 0, 0, 0});
    rows.push_back('{mk(12868, 0, 5000, 0), 0, 0, 0, 0, 0});        // pitch at pi/2
    rows.push_back('{mk(25736, 0, 5000, 0), 0, 0, 0, 0, 0});        // pitch wraps past pi/2
    rows.push_back('{mk(-25736, 0, 5000, 0), 0, 0, 0, 0, 0});       // negative wrap, downhill
    rows.push_back('{mk(0, 0, 5000, 0), 0, 0, 0, 0, 0});            // flat
    rows.push_back('{mk(3000, 12868, 5000, 0), 0, 0, 0, 0, 0});     // cos yaw near zero
    rows.push_back('{mk(3000, 12000, 5000, 0), 0, 0, 0, 0, 0});     // steep yaw, tangent just below the cap
    rows.push_back('{mk(3000, -12000, 5000, 0), 0, 0, 0, 0, 0});
    rows.push_back('{mk(3000, 32767, 5000, 0), 0, 0, 0, 0, 0});     // out-of-range yaw
    rows.push_back('{mk(3000, -32768, 5000, 0), 0, 0, 0, 0, 0});
    rows.push_back('{mk(3000, 2000, 10, 0), 0, 0, 0, 0, 0});        // low speed boost
    rows.push_back('{mk(3000, 2000, 5000, 32767), 0, 0, 0, 0, 0});  // negative headroom
    rows.push_back('{mk(3000, 2000, 5000, -32768), 0, 0, 0, 0, 0});
    rows.push_back('{mk(8000, 1000, -32768, 100), 0, 0, 0, 0, 0});
    rows.push_back('{mk(8000, 1000, 32767, 100), 0, 0, 0, 0, 0});
    rows.push_back('{mk(1, 0, 5000, 0), 0, 0, 0, 0, 0});            // tiny uphill below threshold

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      rw = rows[i];
      if (i == 4) begin
        in_ch.valid <= 1'b0;
        wait_drained();
        regs = '{16'd20000, 16'd16384, 16'd3000, 16'd800, 16'd1000, 16'd200,
                 16'd8192, 16'd6000};
        write_regs(regs);
      end
      tv.comp0 = rw.c0; tv.comp1 = rw.c1; tv.comp2 = rw.c2; tv.comp3 = rw.c3;
      send_period(rw.din, rw.typed, tv);
    end

    for (int ph = 0; ph < 6; ph++) begin
      in_ch.valid <= 1'b0;
      wait_drained();
      case (ph)
        0: regs = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                    16'hffff, 16'h7fff};
        1: regs = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0000,
                    16'h0000, 16'h0000};
        // upper bits set on narrow registers must be dropped
        2: regs = '{16'hffff, 16'h8000, 16'hc000, 16'h8100, 16'hf000, 16'h8400,
                    16'h2000, 16'hffff};
        default: begin
          regs[0] = 16'($urandom_range(500, 32767));
          regs[1] = 16'($urandom_range(0, 32767));
          regs[2] = 16'($urandom_range(0, 8000));
          regs[3] = 16'($urandom_range(0, 3000));
          regs[4] = 16'($signed($urandom_range(0, 40000)) - 32768);
          regs[5] = 16'($urandom_range(0, 600));
          regs[6] = 16'($urandom);
          regs[7] = 16'($urandom_range(0, 32767));
        end
      endcase
      write_regs(regs);
      quiet = (ph == 3);
      n_phase = 225;
      for (int k = 0; k < n_phase; k++) begin
        if (ph == 4 && k == 100) begin
          // let every outstanding result land before going on
          in_ch.valid <= 1'b0;
          while (comp_queue.size() != 0) @(posedge clk_i);
        end
        d = random_period();
        send_period(d, 1'b0, '0);
      end
    end
    quiet = 1'b0;
    in_ch.valid <= 1'b0;
    wait_drained();

    $display("Sent %0d control periods over %0d register settings, %0d results checked.",
             periods_sent, 8, results_seen);
    $display("Covered flat and downhill ramp-off, angle wrap, tangent cap, low-speed boost, headroom.");
    if (errors == 0 && comp_queue.size() == 0) begin
      $display("slope_feedforward_current_top verification clean");
    end else begin
      $display("slope_feedforward_current_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
